// ----- hdl/rwoc_pkg.sv -----
package rwoc_pkg;

  localparam int unsigned FIFO_DEPTH = 1024;
  localparam int unsigned PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned USED_W     = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned ROW_W      = 20;
  localparam int unsigned CNT_W      = 24;
  localparam int unsigned ENTRY_W    = ROW_W + CNT_W;

  localparam logic [ROW_W-1:0] WINDOW_Y_RESET = ROW_W'(2500);
  localparam logic [CNT_W-1:0] CNT_MAX        = {CNT_W{1'b1}};

  localparam logic FUNC_POINT = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OVF_RD,
    S_OVF,
    S_PUSH,
    S_RD,
    S_CHK,
    S_EMIT
  } rwoc_state_e;

  // controller to datapath
  typedef struct packed {
    logic clear;    // end of group
    logic count;    // point on the current row
    logic capture;  // latch new row and overflow flag
    logic rd_head;  // read fifo head entry
    logic retire;   // drop head entry, subtract its count
    logic push;     // store current row and its count
    logic emit;     // load result register, start new row
  } rwoc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic same_row;
    logic retire_ok;
    logic out_free;
  } rwoc_sts_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

  function automatic logic [CNT_W-1:0] sat_sub(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    return (a >= b) ? a - b : '0;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

endpackage

// ----- hdl/rwoc_ctrl.sv -----
module rwoc_ctrl
  import rwoc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      func_i,
  input  rwoc_sts_t sts_i,
  output rwoc_cmd_t cmd_o,
  output logic      in_stall_o
);

  rwoc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (func_i == FUNC_CLEAR) begin
            cmd_o.clear = 1'b1;
          end else if (sts_i.same_row) begin
            cmd_o.count = 1'b1;
          end else begin
            cmd_o.capture = 1'b1;
            state_d       = sts_i.full ? S_OVF_RD : S_PUSH;
          end
        end
      end
      S_OVF_RD: begin
        cmd_o.rd_head = 1'b1;
        state_d       = S_OVF;
      end
      S_OVF: begin
        cmd_o.retire = 1'b1;
        state_d      = S_PUSH;
      end
      S_PUSH: begin
        cmd_o.push = 1'b1;
        state_d    = S_RD;
      end
      S_RD: begin
        if (sts_i.empty) begin
          state_d = S_EMIT;
        end else begin
          cmd_o.rd_head = 1'b1;
          state_d       = S_CHK;
        end
      end
      S_CHK: begin
        if (sts_i.retire_ok) begin
          cmd_o.retire = 1'b1;
          state_d      = S_RD;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ----- hdl/rwoc_dpath.sv -----
module rwoc_dpath
  import rwoc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rwoc_cmd_t        cmd_i,
  output rwoc_sts_t        sts_o,
  input  logic [ROW_W-1:0] row_y_i,
  input  logic             cfg_valid_i,
  input  logic [ROW_W-1:0] cfg_window_y_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [CNT_W-1:0] window_count_o,
  output logic             overflow_o
);

  logic [ENTRY_W-1:0] mem [FIFO_DEPTH];
  logic [ENTRY_W-1:0] rd_q;
  logic [ROW_W-1:0]   rd_row;
  logic [CNT_W-1:0]   rd_cnt;

  logic [PTR_W-1:0]   head_q, head_d, tail_q, tail_d;
  logic [USED_W-1:0]  used_q, used_d;
  logic [ROW_W-1:0]   cur_q, cur_d;
  logic [CNT_W-1:0]   pts_q, pts_d;
  logic [CNT_W-1:0]   total_q, total_d;
  logic [ROW_W-1:0]   win_q;
  logic [ROW_W-1:0]   y_q;
  logic               ovf_q;
  logic               out_valid_q;
  logic [CNT_W-1:0]   out_cnt_q;
  logic               out_ovf_q;
  logic [ROW_W:0]     reach;

  assign rd_row = rd_q[ENTRY_W-1 -: ROW_W];
  assign rd_cnt = rd_q[CNT_W-1:0];
  // stored row leaves the window when row + window < new row, no wrap
  assign reach  = {1'b0, rd_row} + {1'b0, win_q};

  assign sts_o.full      = (used_q == USED_W'(FIFO_DEPTH));
  assign sts_o.empty     = (used_q == '0);
  assign sts_o.same_row  = (row_y_i == cur_q);
  assign sts_o.retire_ok = (reach < {1'b0, y_q});
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  // row fifo storage
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[tail_q] <= {cur_q, pts_q};
    end
    if (cmd_i.rd_head) begin
      rd_q <= mem[head_q];
    end
  end

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    used_d  = used_q;
    cur_d   = cur_q;
    pts_d   = pts_q;
    total_d = total_q;
    if (cmd_i.clear) begin
      head_d  = '0;
      tail_d  = '0;
      used_d  = '0;
      pts_d   = '0;
      total_d = '0;
    end
    if (cmd_i.count) begin
      pts_d   = sat_inc(pts_q);
      total_d = sat_inc(total_q);
    end
    if (cmd_i.retire) begin
      total_d = sat_sub(total_q, rd_cnt);
      head_d  = ptr_inc(head_q);
      used_d  = used_q - USED_W'(1);
    end
    if (cmd_i.push) begin
      tail_d = ptr_inc(tail_q);
      used_d = used_q + USED_W'(1);
    end
    if (cmd_i.emit) begin
      cur_d   = y_q;
      pts_d   = CNT_W'(1);
      total_d = sat_inc(total_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      used_q      <= '0;
      cur_q       <= '0;
      pts_q       <= '0;
      total_q     <= '0;
      win_q       <= WINDOW_Y_RESET;
      out_valid_q <= 1'b0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      used_q  <= used_d;
      cur_q   <= cur_d;
      pts_q   <= pts_d;
      total_q <= total_d;
      if (cfg_valid_i) begin
        win_q <= cfg_window_y_i;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      y_q   <= row_y_i;
      ovf_q <= sts_o.full;
    end
    if (cmd_i.emit) begin
      out_cnt_q <= total_q;
      out_ovf_q <= ovf_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign window_count_o = out_cnt_q;
  assign overflow_o     = out_ovf_q;

endmodule

// ----- hdl/row_window_occupancy_counter.sv -----
// row window occupancy counter: sliding count of points over a window of rows
// a point on the current row or end of group is absorbed at its transfer (no result);
//   a row change captures its row, drops the oldest stored row on overflow, stores the
//   finished row, retires stored rows from the oldest while they are out of the window,
//   then loads its result; throughput: one item per cycle while the row holds; a row
//   change holds the input off until its result is loaded, the next transfer can follow in the cycle after
// reset: asynchronous active low; fifo empty, counters and row zero, window 2500
module row_window_occupancy_counter
  import rwoc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // input item channel
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             func_i,
  input  logic [ROW_W-1:0] row_y_i,
  // result channel
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [CNT_W-1:0] window_count_o,
  output logic             overflow_o,
  // window register write channel
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [ROW_W-1:0] cfg_window_y_i
);

  rwoc_cmd_t cmd;
  rwoc_sts_t sts;

  // register writes are always taken and registered at their transfer
  assign cfg_ready_o = 1'b1;

  // sequencer: takes items in idle, then walks overflow retire, push, the retire loop and emit
  rwoc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  // row fifo, counters, window register and result register
  rwoc_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .row_y_i        (row_y_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_window_y_i (cfg_window_y_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .window_count_o (window_count_o),
    .overflow_o     (overflow_o)
  );

endmodule

// ----- bench/row_window_occupancy_counter_tb.sv -----
`timescale 1ns / 100ps

module row_window_occupancy_counter_tb;
  import rwoc_pkg::*;

  localparam int unsigned ROW_MAX     = (1 << ROW_W) - 1;
  localparam int unsigned ROW_SUM_W   = ROW_W + 1;
  // a point on the current row or an end of group is absorbed at its transfer
  localparam int unsigned SETTLE_CYC  = 20;
  localparam int unsigned HOLD_CYC    = 400;
  // longest legal quiet stretch is a full fifo retired in one go
  localparam int unsigned QUIET_LIMIT = 10000;

  typedef struct packed {
    logic [CNT_W-1:0] window_count;
    logic             overflow;
  } window_result_t;

  // dut ports, all inputs known from time zero
  logic             clk_i          = 1'b0;
  logic             rst_ni         = 1'b0;
  logic             in_valid_i     = 1'b0;
  logic             in_stall_o;
  logic             func_i         = FUNC_POINT;
  logic [ROW_W-1:0] row_y_i        = '0;
  logic             out_valid_o;
  logic             out_stall_i    = 1'b0;
  logic [CNT_W-1:0] window_count_o;
  logic             overflow_o;
  logic             cfg_valid_i    = 1'b0;
  logic             cfg_ready_o;
  logic [ROW_W-1:0] cfg_window_y_i = '0;

  // idle rates in percent, set per phase
  int unsigned src_idle_pct  = 0;
  int unsigned sink_idle_pct = 0;

  // long receiver hold-off: the test bumps the request count, the receiver counts
  int unsigned hold_requests = 0;

  int unsigned errors = 0;

  // shadow of the block: finished-row fifo, current row and counters
  logic [ROW_W-1:0] shadow_rows   [FIFO_DEPTH];
  logic [CNT_W-1:0] shadow_counts [FIFO_DEPTH];
  int unsigned      shadow_head   = 0;
  int unsigned      shadow_tail   = 0;
  int unsigned      shadow_used   = 0;
  logic [ROW_W-1:0] shadow_row    = '0;
  logic [CNT_W-1:0] shadow_points = '0;
  logic [CNT_W-1:0] shadow_total  = '0;
  logic [ROW_W-1:0] shadow_window = WINDOW_Y_RESET;

  // results owed by the block, oldest first
  window_result_t expected_counts [$];

  row_window_occupancy_counter i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .row_y_i        (row_y_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .window_count_o (window_count_o),
    .overflow_o     (overflow_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_window_y_i (cfg_window_y_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // window count predictor
  // ---------------------------------------------------------------------------

  // drop the oldest stored row and take its points out of the window total
  function automatic void retire_oldest_row();
    if (shadow_total >= shadow_counts[shadow_head]) begin
      shadow_total = shadow_total - shadow_counts[shadow_head];
    end else begin
      shadow_total = '0;
    end
    shadow_head = (shadow_head + 1 == FIFO_DEPTH) ? 0 : shadow_head + 1;
    shadow_used--;
  endfunction

  task automatic predict_window_count(input logic op, input logic [ROW_W-1:0] y);
    window_result_t res;
    if (op == FUNC_CLEAR) begin
      // end of group empties the fifo, the current row survives
      shadow_head   = 0;
      shadow_tail   = 0;
      shadow_used   = 0;
      shadow_points = '0;
      shadow_total  = '0;
    end else begin
      if (y != shadow_row) begin
        res.overflow = 1'b0;
        // full fifo: oldest row goes early and the result is flagged
        if (shadow_used >= FIFO_DEPTH) begin
          retire_oldest_row();
          res.overflow = 1'b1;
        end
        shadow_rows[shadow_tail]   = shadow_row;
        shadow_counts[shadow_tail] = shadow_points;
        shadow_tail   = (shadow_tail + 1 == FIFO_DEPTH) ? 0 : shadow_tail + 1;
        shadow_used++;
        shadow_points = '0;
        // a row leaves once row + window falls below the new row, no wrap
        while (shadow_used > 0) begin
          if (ROW_SUM_W'(shadow_rows[shadow_head]) + ROW_SUM_W'(shadow_window)
              < ROW_SUM_W'(y)) begin
            retire_oldest_row();
          end else begin
            break;
          end
        end
        shadow_row       = y;
        res.window_count = shadow_total;
        expected_counts.push_back(res);
      end
      // count the new point after the result, both counters saturate
      if (shadow_points != CNT_MAX) shadow_points = shadow_points + 1'b1;
      if (shadow_total != CNT_MAX) shadow_total = shadow_total + 1'b1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // sender, receiver, checker, watchdog
  // ---------------------------------------------------------------------------

  // offer one item, idling first at the sender's rate; valid stays high after
  // the transfer so back-to-back items need no extra edge
  task automatic send_item(input logic op, input logic [ROW_W-1:0] y);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= op;
    row_y_i    <= y;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_window_count(op, y);
  endtask

  // stop offering and wait until every owed result has come, then let the
  // block finish any point or clear that produces nothing
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_counts.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // window register transfer; only called with the block idle
  task automatic write_window(input logic [ROW_W-1:0] w);
    cfg_valid_i    <= 1'b1;
    cfg_window_y_i <= w;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i    <= 1'b0;
    shadow_window = w;
  endtask

  // receiver: random stall at its rate, or a long counted hold-off on request
  always @(posedge clk_i) begin : drive_out_stall
    int unsigned hold_served;
    int unsigned hold_left;
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYC;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < sink_idle_pct);
    end
  end

  // every result transfer is matched against the oldest prediction
  always @(posedge clk_i) begin : check_results
    window_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_counts.size() == 0) begin
        $error("unexpected result: window_count %0d overflow %0b",
               window_count_o, overflow_o);
        errors++;
      end else begin
        want = expected_counts[0];
        expected_counts.delete(0);
        if (window_count_o !== want.window_count) begin
          $error("window_count mismatch: expected %0d, actual %0d",
                 want.window_count, window_count_o);
          errors++;
        end
        if (overflow_o !== want.overflow) begin
          $error("overflow mismatch: expected %0b, actual %0b",
                 want.overflow, overflow_o);
          errors++;
        end
      end
    end
  end

  // ends a hung run: counts cycles without any transfer on any channel
  always @(posedge clk_i) begin : watchdog
    int unsigned quiet;
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
        || (cfg_valid_i && cfg_ready_o)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // hand-picked rows around the window edges, group clears and the extremes
  task automatic test_directed();
    // reset window value, reset current row is zero
    send_item(FUNC_POINT, ROW_W'(0));        // same as reset row: counted, no result
    send_item(FUNC_POINT, ROW_W'(0));
    send_item(FUNC_POINT, ROW_W'(3000));     // row 0 falls out of the window
    send_item(FUNC_POINT, ROW_W'(3000));
    send_item(FUNC_POINT, ROW_W'(4000));
    send_item(FUNC_POINT, ROW_W'(5500));     // 3000 + 2500 == 5500 stays in
    send_item(FUNC_POINT, ROW_W'(5501));     // and now leaves
    send_item(FUNC_CLEAR, ROW_W'(ROW_MAX));
    send_item(FUNC_POINT, ROW_W'(5501));     // row kept across clear: no result
    send_item(FUNC_POINT, ROW_W'(ROW_MAX));
    send_item(FUNC_POINT, ROW_W'(0));        // going back down retires nothing
    send_item(FUNC_CLEAR, ROW_W'(0));
    send_item(FUNC_CLEAR, ROW_W'(0));
    send_item(FUNC_POINT, ROW_W'(2500));     // row equal to window retires nothing
    wait_drained();
    // zero window: a stored row stays only while it is not below the new row
    write_window('0);
    send_item(FUNC_POINT, ROW_W'(1));
    send_item(FUNC_POINT, ROW_W'(1));
    send_item(FUNC_POINT, ROW_W'(2));
    send_item(FUNC_POINT, ROW_W'(2));
    send_item(FUNC_POINT, ROW_W'(0));
    wait_drained();
    // widest window: nothing can ever leave
    write_window(ROW_W'(ROW_MAX));
    send_item(FUNC_POINT, ROW_W'(ROW_MAX));
    send_item(FUNC_POINT, ROW_W'(524288));
    send_item(FUNC_POINT, ROW_W'(0));
    send_item(FUNC_POINT, ROW_W'(ROW_MAX));
    wait_drained();
  endtask

  // mostly ascending rows with repeats, plus clears and rows anywhere
  task automatic send_row_mix(input int unsigned n_items, input int unsigned span);
    int unsigned pick;
    int unsigned next_row;
    logic [ROW_W-1:0] y;
    y = ROW_W'($urandom);
    repeat (n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        send_item(FUNC_CLEAR, ROW_W'($urandom));
      end else if (pick < 45) begin
        send_item(FUNC_POINT, y);
      end else if (pick < 90) begin
        next_row = int'(y) + $urandom_range(1, span);
        // past the top restart low, like a new tile
        y = (next_row > ROW_MAX) ? ROW_W'($urandom_range(0, span)) : ROW_W'(next_row);
        send_item(FUNC_POINT, y);
      end else begin
        y = ROW_W'($urandom);
        send_item(FUNC_POINT, y);
      end
    end
  endtask

  task automatic test_row_mix();
    int unsigned w;
    w = $urandom_range(0, 64);
    write_window(ROW_W'(w));
    send_row_mix(50, 16);
    wait_drained();
    w = $urandom_range(16, 2000);
    write_window(ROW_W'(w));
    send_row_mix(50, w / 4 + 2);
    wait_drained();
    write_window(WINDOW_Y_RESET);
    send_row_mix(50, 1200);
    wait_drained();
    w = $urandom_range(0, ROW_MAX);
    write_window(ROW_W'(w));
    send_row_mix(50, w / 3 + 2);
    wait_drained();
  endtask

  // more distinct rows than the fifo holds, none ever leaving the window
  task automatic test_fifo_overflow();
    int unsigned base;
    int unsigned step;
    int unsigned y;
    write_window(ROW_W'(ROW_MAX));
    send_item(FUNC_CLEAR, ROW_W'($urandom));
    base = $urandom_range(1, 1000);
    step = $urandom_range(1, 900);
    for (int i = 0; i < FIFO_DEPTH + 40; i++) begin
      y = base + i * step;
      send_item(FUNC_POINT, ROW_W'(y));
      if ($urandom_range(0, 9) == 0) send_item(FUNC_POINT, ROW_W'(y));
    end
    wait_drained();
  endtask

  // full fifo, zero window, top row: every stored row leaves in one step
  task automatic test_bulk_retire();
    write_window('0);
    send_item(FUNC_POINT, ROW_W'(ROW_MAX));
    send_item(FUNC_POINT, ROW_W'(ROW_MAX));
    send_item(FUNC_POINT, ROW_W'(0));
    send_item(FUNC_POINT, ROW_W'(1));
    wait_drained();
  endtask

  // receiver holds off while row changes keep coming, so the block backs up
  // and stalls its input; afterwards the sender waits for every result, then sends a mix
  task automatic test_backpressure();
    int unsigned y;
    write_window(ROW_W'(100));
    hold_requests++;
    y = $urandom_range(0, 1000);
    repeat (40) begin
      y = y + $urandom_range(1, 60);
      send_item(FUNC_POINT, ROW_W'(y));
    end
    wait_drained();
    send_row_mix(60, 40);
    wait_drained();
  endtask

  initial begin : run_tests
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src_idle_pct  = 11;
    sink_idle_pct = 60;
    test_directed();
    test_row_mix();

    src_idle_pct  = 60;
    sink_idle_pct = 11;
    test_fifo_overflow();
    test_bulk_retire();

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_backpressure();

    // catch any stray result after the last one owed
    wait_drained();
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
